// File: hw/rtl/ccs_pkg.sv
`default_nettype none
package ccs_pkg;

  // Largest matrix dimension held in the column start tables
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 3;
  localparam int RESULT_CAP = 64;

  // Entry slots per matrix and the address width of the entry stores
  localparam int MAX_NONZEROS = 64;
  localparam int NZ_AW = $clog2(MAX_NONZEROS);

  // Packed widths of the stream payloads
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Stored entry: row in the top bits, Q16.16 value below
  localparam int ENTRY_W = 35;

  typedef enum logic [2:0] {
    KIND_A_ENTRY = 3'd0,
    KIND_A_START = 3'd1,
    KIND_B_ENTRY = 3'd2,
    KIND_B_START = 3'd3,
    KIND_MULTIPLY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_ROWS_A    = 3'd0,
    REG_INNER_DIM = 3'd1,
    REG_COLS_B    = 3'd2,
    REG_NNZ_A     = 3'd3,
    REG_NNZ_B     = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELEM,
    ST_LK_S,
    ST_LK_E,
    ST_LK_A,
    ST_LK_D,
    ST_LK_RET,
    ST_MUL,
    ST_ACC,
    ST_NEXT_I,
    ST_EVAL,
    ST_PUSH,
    ST_NEXT_JK,
    ST_FINISH
  } state_t;

  // Controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/ccs_ram.sv
`default_nettype none
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/ccs_mac.sv
`default_nettype none
module ccs_mac (
  input  wire logic                clk,
  input  wire ccs_pkg::mac_ctrl_t  ctrl,
  input  wire logic signed [31:0]  x,
  input  wire logic signed [31:0]  y,
  output logic signed [31:0]       q
);
  import ccs_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [64:0] sum;
  logic signed [63:0] acc_next;
  logic signed [47:0] shifted;

  // Register the Q32.32 product before the add
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= x * y;
    end
  end

  // Add with saturation at the 64-bit limits
  always_comb begin
    sum = {acc[63], acc} + {prod[63], prod};
    if (sum[64] != sum[63]) begin
      acc_next = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_next = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

  // Floor shift to Q16.16 and clamp to 32 bits
  always_comb begin
    shifted = acc[63:16];
    if (shifted[47:31] == {17{1'b0}} || shifted[47:31] == {17{1'b1}}) begin
      q = shifted[31:0];
    end else if (shifted[47]) begin
      q = {1'b1, 31'd0};
    end else begin
      q = {1'b0, {31{1'b1}}};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sparse_ccs_matrix_multiply.sv
`default_nettype none
// Channel  | Dir | tdata (low bit up)                               | tuser      | tlast
// s_       | in  | position 6, row_number 6, entry_value 32         | kind 3     | -
// m_       | out | product_value 32, product_row 3, product_column 3, | valid_res 1 | last
//          |     | entry_index 6                                    |            |
// cfg_     | in  | cfg_index selects register, cfg_data 7 bits      | -          | -
//
// Load commands may follow back to back. A multiply works through each result element
// (with a push state per pushed result) and, per inner index, an advance and an A column
// lookup that scans the column's entries for the wanted row, ending on a hit or a miss;
// a nonzero A value adds a like B lookup and a pass through the shared MAC.
// Reset (rst, synchronous) restores the registers; entry stores are not cleared.
// The block takes no new transaction until the last result of a multiply has
// been loaded into the output register; a stalled output halts the sequencer.
module sparse_ccs_matrix_multiply (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // position, row_number, entry_value
  input  wire logic [2:0]  s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // product_value, product_row, product_column,
                                      // entry_index
  output logic             m_tuser,   // valid_res
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import ccs_pkg::*;

  // Configuration registers
  logic [3:0] rows_a, inner_dim, cols_b;
  logic [6:0] nnz_a, nnz_b;

  // Clipped sizes captured at multiply start
  logic [3:0] m_dim, n_dim, p_dim;
  logic [6:0] na, nb;
  logic [3:0] m_clip, n_clip, p_clip;
  logic [6:0] na_clip, nb_clip;

  state_t state, state_next;

  logic [6:0] a_start [MAX_DIM];
  logic [6:0] b_start [MAX_DIM];

  // Loop counters and lookup registers
  logic [3:0] k_cnt, j_cnt, i_cnt;
  logic       sel_b;
  logic [2:0] lk_row;
  logic [3:0] lk_col;
  logic [6:0] scan_i, scan_end;
  logic signed [31:0] lk_val, xval;
  logic [6:0] cnt;

  // Held result, emitted once the next one or the end is known
  logic        have_pend;
  logic [31:0] pend_val;
  logic [2:0]  pend_row, pend_col;
  logic [5:0]  pend_idx;

  logic [5:0]  in_pos, in_rown;
  logic [31:0] in_val;
  kind_t       in_kind;
  logic        in_fire, can_push, load_out;

  logic [ENTRY_W-1:0] a_rdata, b_rdata, sel_rdata;
  logic               a_we, b_we;
  mac_ctrl_t          mac_ctrl;
  logic signed [31:0] q_res;

  logic [6:0] start_cur, start_nx, nnz_sel, end_raw;
  logic [3:0] ncols_sel;
  logic [2:0] col_nx;
  logic       scan_ok, res_take;

  assign in_pos  = s_tdata[5:0];
  assign in_rown = s_tdata[11:6];
  assign in_val  = s_tdata[43:12];
  assign in_kind = kind_t'(s_tuser);
  assign in_fire = s_tvalid && s_tready;
  assign can_push = !m_tvalid || m_tready;

  assign m_clip  = (rows_a > 4'(MAX_DIM)) ? 4'(MAX_DIM) : rows_a;
  assign n_clip  = (inner_dim > 4'(MAX_DIM)) ? 4'(MAX_DIM) : inner_dim;
  assign p_clip  = (cols_b > 4'(MAX_DIM)) ? 4'(MAX_DIM) : cols_b;
  assign na_clip = (32'(nnz_a) > MAX_NONZEROS) ? 7'(MAX_NONZEROS) : nnz_a;
  assign nb_clip = (32'(nnz_b) > MAX_NONZEROS) ? 7'(MAX_NONZEROS) : nnz_b;

  // Lookup selections between A and B
  assign col_nx    = lk_col[DIM_W-1:0] + 3'd1;
  assign start_cur = sel_b ? b_start[lk_col[DIM_W-1:0]] : a_start[lk_col[DIM_W-1:0]];
  assign start_nx  = sel_b ? b_start[col_nx] : a_start[col_nx];
  assign nnz_sel   = sel_b ? nb : na;
  assign ncols_sel = sel_b ? p_dim : n_dim;
  assign end_raw   = (lk_col + 4'd1 == ncols_sel) ? nnz_sel : start_nx;
  assign sel_rdata = sel_b ? b_rdata : a_rdata;
  assign scan_ok   = (scan_i < scan_end) && (32'(scan_i) < MAX_NONZEROS);
  assign res_take  = (q_res != 32'sd0) && (32'(cnt) < RESULT_CAP);

  // Entry stores
  assign a_we = in_fire && in_kind == KIND_A_ENTRY && 32'(in_pos) < MAX_NONZEROS;
  assign b_we = in_fire && in_kind == KIND_B_ENTRY && 32'(in_pos) < MAX_NONZEROS;

  ccs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NONZEROS)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (NZ_AW'(in_pos)),
    .wdata ({in_rown[2:0], in_val}),
    .raddr (NZ_AW'(scan_i)),
    .rdata (a_rdata)
  );

  ccs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NONZEROS)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (NZ_AW'(in_pos)),
    .wdata ({in_rown[2:0], in_val}),
    .raddr (NZ_AW'(scan_i)),
    .rdata (b_rdata)
  );

  ccs_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .x    (xval),
    .y    (lk_val),
    .q    (q_res)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= 4'd8;
      inner_dim <= 4'd8;
      cols_b    <= 4'd8;
      nnz_a     <= 7'd0;
      nnz_b     <= 7'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ROWS_A:    rows_a    <= cfg_data[3:0];
        REG_INNER_DIM: inner_dim <= cfg_data[3:0];
        REG_COLS_B:    cols_b    <= cfg_data[3:0];
        REG_NNZ_A:     nnz_a     <= cfg_data;
        REG_NNZ_B:     nnz_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Column start tables
  always_ff @(posedge clk) begin
    if (in_fire && in_pos < 6'(MAX_DIM)) begin
      if (in_kind == KIND_A_START) begin
        a_start[in_pos[DIM_W-1:0]] <= {1'b0, in_rown};
      end
      if (in_kind == KIND_B_START) begin
        b_start[in_pos[DIM_W-1:0]] <= {1'b0, in_rown};
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_kind == KIND_MULTIPLY) begin
          if (m_clip == 4'd0 || n_clip == 4'd0 || p_clip == 4'd0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ELEM;
          end
        end
      end
      ST_ELEM:   state_next = ST_LK_S;
      ST_LK_S:   state_next = (start_cur == nnz_sel) ? ST_LK_RET : ST_LK_E;
      ST_LK_E:   state_next = ST_LK_A;
      ST_LK_A:   state_next = scan_ok ? ST_LK_D : ST_LK_RET;
      ST_LK_D:   state_next = (sel_rdata[ENTRY_W-1:32] == lk_row) ? ST_LK_RET : ST_LK_A;
      ST_LK_RET: begin
        if (lk_val == 32'sd0) begin
          state_next = ST_NEXT_I;
        end else begin
          state_next = sel_b ? ST_MUL : ST_LK_S;
        end
      end
      ST_MUL:    state_next = ST_ACC;
      ST_ACC:    state_next = ST_NEXT_I;
      ST_NEXT_I: state_next = (i_cnt + 4'd1 < n_dim) ? ST_LK_S : ST_EVAL;
      ST_EVAL: begin
        if (res_take && have_pend) begin
          state_next = ST_PUSH;
        end else begin
          state_next = ST_NEXT_JK;
        end
      end
      ST_PUSH:   state_next = can_push ? ST_NEXT_JK : ST_PUSH;
      ST_NEXT_JK: begin
        if (j_cnt + 4'd1 < m_dim || k_cnt + 4'd1 < p_dim) begin
          state_next = ST_ELEM;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = can_push ? ST_IDLE : ST_FINISH;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready       = (state == ST_IDLE);
    mac_ctrl.clear  = (state == ST_ELEM);
    mac_ctrl.mul_en = (state == ST_MUL);
    mac_ctrl.acc_en = (state == ST_ACC);
    load_out       = (state == ST_PUSH || state == ST_FINISH) && can_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend <= 1'b0;
      cnt       <= 7'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire && in_kind == KIND_MULTIPLY) begin
            m_dim     <= m_clip;
            n_dim     <= n_clip;
            p_dim     <= p_clip;
            na        <= na_clip;
            nb        <= nb_clip;
            k_cnt     <= 4'd0;
            j_cnt     <= 4'd0;
            cnt       <= 7'd0;
            have_pend <= 1'b0;
          end
        end
        ST_ELEM: begin
          i_cnt  <= 4'd0;
          sel_b  <= 1'b0;
          lk_row <= j_cnt[2:0];
          lk_col <= 4'd0;
        end
        ST_LK_S: begin
          scan_i <= start_cur;
          lk_val <= 32'sd0;
        end
        ST_LK_E: scan_end <= (end_raw > nnz_sel) ? nnz_sel : end_raw;
        ST_LK_D: begin
          if (sel_rdata[ENTRY_W-1:32] == lk_row) begin
            lk_val <= sel_rdata[31:0];
          end else begin
            scan_i <= scan_i + 7'd1;
          end
        end
        ST_LK_RET: begin
          // A found: look up the B element in column k
          if (!sel_b && lk_val != 32'sd0) begin
            xval   <= lk_val;
            sel_b  <= 1'b1;
            lk_row <= i_cnt[2:0];
            lk_col <= k_cnt;
          end
        end
        ST_NEXT_I: begin
          i_cnt  <= i_cnt + 4'd1;
          sel_b  <= 1'b0;
          lk_row <= j_cnt[2:0];
          lk_col <= i_cnt + 4'd1;
        end
        ST_EVAL: begin
          if (res_take && !have_pend) begin
            have_pend <= 1'b1;
            pend_val  <= q_res;
            pend_row  <= j_cnt[2:0];
            pend_col  <= k_cnt[2:0];
            pend_idx  <= cnt[5:0];
            cnt       <= cnt + 7'd1;
          end
        end
        ST_PUSH: begin
          if (can_push) begin
            pend_val <= q_res;
            pend_row <= j_cnt[2:0];
            pend_col <= k_cnt[2:0];
            pend_idx <= cnt[5:0];
            cnt      <= cnt + 7'd1;
          end
        end
        ST_NEXT_JK: begin
          if (j_cnt + 4'd1 < m_dim) begin
            j_cnt <= j_cnt + 4'd1;
          end else begin
            j_cnt <= 4'd0;
            k_cnt <= k_cnt + 4'd1;
          end
        end
        ST_FINISH: begin
          if (can_push) begin
            have_pend <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (have_pend) begin
        m_tdata <= {4'd0, pend_idx, pend_col, pend_row, pend_val};
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
      end
      m_tlast <= (state == ST_FINISH);
    end
  end

  // An empty product is always the final transaction
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("empty product result without last");

  // The result count never passes the cap
  a_cap: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= RESULT_CAP)
    else $error("result count beyond cap");

  // A multiply command holds off further input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_kind == KIND_MULTIPLY |=> !s_tready)
    else $error("input accepted during multiply");

  // The held result is gone once the final transaction is loaded
  a_flush: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && can_push |=> !have_pend)
    else $error("held result left after finish");

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ccs_pkg::*;

  localparam int SLOTS      = 64;
  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_LEN   = 3000;
  localparam int DRAIN_WAIT = 300;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [5:0]  index;
    logic        present;
    logic        final_flag;
  } product_t;

  // Models the loaded matrices and queues the product elements of each multiply
  class product_scoreboard;
    int unsigned rows_a, inner_dim, cols_b, nnz_a, nnz_b;
    logic signed [31:0] a_val[SLOTS];
    logic [2:0]         a_row[SLOTS];
    logic [5:0]         a_start[MAX_DIM];
    logic signed [31:0] b_val[SLOTS];
    logic [2:0]         b_row[SLOTS];
    logic [5:0]         b_start[MAX_DIM];
    product_t pending[$];
    int errors;
    int checked;

    function new();
      rows_a = 8; inner_dim = 8; cols_b = 8; nnz_a = 0; nnz_b = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [6:0] d);
      case (idx)
        REG_ROWS_A:    rows_a = d[3:0];
        REG_INNER_DIM: inner_dim = d[3:0];
        REG_COLS_B:    cols_b = d[3:0];
        REG_NNZ_A:     nnz_a = d;
        REG_NNZ_B:     nnz_b = d;
        default: ;
      endcase
    endfunction

    // Scan a column for the first entry on the wanted row
    function longint fetch(bit from_b, int unsigned ncols, int unsigned cnt,
                           int unsigned row, int unsigned col);
      int unsigned s;
      int unsigned e;
      if (col >= ncols || col >= MAX_DIM) return 0;
      s = from_b ? b_start[col] : a_start[col];
      if (s == cnt) return 0;
      if (col + 1 == ncols) e = cnt;
      else e = from_b ? b_start[col + 1] : a_start[col + 1];
      if (e > cnt) e = cnt;
      for (int unsigned i = s; i < e && i < SLOTS; i++) begin
        if (from_b && b_row[i] == row) return b_val[i];
        if (!from_b && a_row[i] == row) return a_val[i];
      end
      return 0;
    endfunction

    function longint sat_sum(longint x, longint y);
      logic signed [64:0] s;
      s = {x[63], x} + {y[63], y};
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    function logic [31:0] narrow(longint acc);
      longint q;
      q = acc >>> 16;
      if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -64'sd2147483648) return 32'h8000_0000;
      return q[31:0];
    endfunction

    function void note_item(logic [2:0] kind, logic [5:0] pos, logic [5:0] rn,
                            logic [31:0] val);
      int unsigned m, n, p, na, nb, cnt;
      longint acc;
      logic [31:0] r;
      product_t el;
      case (kind)
        KIND_A_ENTRY: begin a_val[pos] = val; a_row[pos] = rn[2:0]; end
        KIND_A_START: if (pos < MAX_DIM) a_start[pos[2:0]] = rn;
        KIND_B_ENTRY: begin b_val[pos] = val; b_row[pos] = rn[2:0]; end
        KIND_B_START: if (pos < MAX_DIM) b_start[pos[2:0]] = rn;
        KIND_MULTIPLY: begin
          m = rows_a > MAX_DIM ? MAX_DIM : rows_a;
          n = inner_dim > MAX_DIM ? MAX_DIM : inner_dim;
          p = cols_b > MAX_DIM ? MAX_DIM : cols_b;
          na = nnz_a > SLOTS ? SLOTS : nnz_a;
          nb = nnz_b > SLOTS ? SLOTS : nnz_b;
          cnt = 0;
          for (int unsigned k = 0; k < p; k++)
            for (int unsigned j = 0; j < m; j++) begin
              acc = 0;
              for (int unsigned i = 0; i < n; i++)
                acc = sat_sum(acc, fetch(0, n, na, j, i) * fetch(1, p, nb, i, k));
              r = narrow(acc);
              if (r != 0 && cnt < RESULT_CAP) begin
                el.value = r; el.row = 3'(j); el.col = 3'(k); el.index = 6'(cnt);
                el.present = 1; el.final_flag = 0;
                pending.insert(pending.size(), el);
                cnt++;
              end
            end
          if (cnt == 0) begin
            el.value = 0; el.row = 0; el.col = 0; el.index = 0;
            el.present = 0; el.final_flag = 1;
            pending.insert(pending.size(), el);
          end else begin
            pending[pending.size() - 1].final_flag = 1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(product_t got);
      product_t want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected product element value %h", got.value);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.index !== want.index || got.present !== want.present ||
          got.final_flag !== want.final_flag) begin
        errors++;
        if (errors <= 10)
          $display("element %0d: want v=%h r=%0d c=%0d i=%0d p=%b l=%b, got v=%h r=%0d c=%0d i=%0d p=%b l=%b",
                   checked, want.value, want.row, want.col, want.index, want.present,
                   want.final_flag, got.value, got.row, got.col, got.index, got.present,
                   got.final_flag);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  product_scoreboard board = new();
  int  burst_left = 0;
  bit  no_gaps = 0;
  int  stall_mode = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  int  sent = 0;
  int  multiplies = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  sparse_ccs_matrix_multiply u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver: long hold-off on request, otherwise the stall pattern of the phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = HOLD_LEN;
      m_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 0;
    end else if (stall_mode == 0) begin
      m_tready <= 1;
    end else if (stall_mode == 1) begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end else begin
      m_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  // Check output transactions and watch for a hung block
  always @(posedge clk) begin
    product_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata[31:0];
      got.row = m_tdata[34:32];
      got.col = m_tdata[37:35];
      got.index = m_tdata[43:38];
      got.present = m_tuser;
      got.final_flag = m_tlast;
      board.check(got);
    end
    if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(logic [2:0] kind, logic [5:0] pos, logic [5:0] rn,
                      logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {4'b0, val, rn, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(kind, pos, rn, val);
    sent++;
    if (kind == KIND_MULTIPLY) multiplies++;
  endtask

  task automatic stop_sending();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  // Drop valid and wait for every product element, then let the block settle
  task automatic drain();
    stop_sending();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [6:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic set_shape(logic [6:0] m, logic [6:0] n, logic [6:0] p,
                           logic [6:0] na, logic [6:0] nb);
    write_reg(REG_ROWS_A, m);
    write_reg(REG_INNER_DIM, n);
    write_reg(REG_COLS_B, p);
    write_reg(REG_NNZ_A, na);
    write_reg(REG_NNZ_B, nb);
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 1)) return $urandom();
    return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
  endfunction

  // Load a well-formed compressed-column matrix with random content
  task automatic load_matrix(bit is_b, int unsigned ncols, int unsigned nrows,
                             int unsigned cnt);
    int unsigned st;
    st = 0;
    for (int unsigned c = 0; c < ncols; c++) begin
      send(is_b ? KIND_B_START : KIND_A_START, 6'(c), 6'(st), 32'd0);
      if (st < cnt) st = $urandom_range(st, cnt);
    end
    for (int unsigned e = 0; e < cnt; e++)
      send(is_b ? KIND_B_ENTRY : KIND_A_ENTRY, 6'(e),
           6'(($urandom_range(0, 7) << 3) | $urandom_range(0, nrows - 1)), rand_value());
  endtask

  initial begin
    int m, n, p, na, nb;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Column starts for an empty product with no entries counted
    no_gaps = 1;
    for (int c = 0; c < MAX_DIM; c++) begin
      send(KIND_A_START, 6'(c), 0, 0);
      send(KIND_B_START, 6'(c), 0, 0);
    end
    send(KIND_MULTIPLY, 0, 0, 0);
    drain();

    // Single element: positive and negative saturation to 32 bits
    set_shape(1, 1, 1, 1, 1);
    send(KIND_A_ENTRY, 0, 0, 32'h8000_0000);
    send(KIND_B_ENTRY, 0, 6'h38, 32'h8000_0000);
    send(KIND_MULTIPLY, 0, 0, 0);
    send(KIND_B_ENTRY, 0, 0, 32'h7FFF_FFFF);
    send(KIND_MULTIPLY, 0, 0, 0);
    // Ignored kinds and an out of range column
    send(3'd5, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
    send(3'd6, 0, 0, 0);
    send(3'd7, 6'h2A, 6'h15, 32'h5555_5555);
    send(KIND_A_START, 6'h3F, 6'h3F, 0);
    drain();

    // Full inner sum that overflows 64 bits, then a start past the end
    set_shape(1, 8, 1, 8, 8);
    for (int i = 0; i < 8; i++) begin
      send(KIND_A_START, 6'(i), 6'(i), 0);
      send(KIND_A_ENTRY, 6'(i), 0, 32'h8000_0000);
      send(KIND_B_ENTRY, 6'(i), 6'(i), 32'h8000_0000);
    end
    send(KIND_MULTIPLY, 0, 0, 0);
    send(KIND_A_START, 0, 6'h3F, 0);
    send(KIND_MULTIPLY, 0, 0, 0);
    drain();

    // Zero dimension and oversized registers
    set_shape(0, 8, 8, 8, 8);
    send(KIND_MULTIPLY, 0, 0, 0);
    drain();
    set_shape(15, 15, 15, 127, 127);
    // Park every column start on the top slot so only that slot is scanned
    for (int c = 0; c < MAX_DIM; c++) begin
      send(KIND_A_START, 6'(c), 6'h3F, 0);
      send(KIND_B_START, 6'(c), 6'h3F, 0);
    end
    send(KIND_A_ENTRY, 6'h3F, 6'h07, 32'h0003_0000);
    send(KIND_B_ENTRY, 6'h3F, 6'h07, 32'hFFFE_8000);
    send(KIND_MULTIPLY, 0, 0, 0);
    drain();

    // Random phases of well-formed matrices with a sprinkling of noise
    for (int ph = 0; ph < 7; ph++) begin
      no_gaps = (ph % 3 == 0);
      stall_mode = ph % 3;
      if (ph == 6) begin
        m = 8; n = 8; p = 8; na = 16; nb = 16;
      end else begin
        m = $urandom_range(1, 4); n = $urandom_range(1, 4); p = $urandom_range(1, 4);
        na = $urandom_range(0, 8); nb = $urandom_range(0, 8);
      end
      set_shape(7'(m), 7'(n), 7'(p), 7'(na), 7'(nb));
      load_matrix(0, n, m, na);
      load_matrix(1, p, n, nb);
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 3) == 0)
          send(3'($urandom_range(0, 7)), 6'($urandom()), 6'($urandom()), $urandom());
        else
          send(($urandom_range(0, 1) ? KIND_A_ENTRY : KIND_B_ENTRY),
               6'($urandom_range(0, na > nb ? na : nb)), 6'($urandom()), rand_value());
      end
      send(KIND_MULTIPLY, 0, 0, 0);
      if (ph == 4) hold_req = 1;
      send(KIND_MULTIPLY, 0, 0, 0);
      send(KIND_MULTIPLY, 0, 0, 0);
      drain();
    end

    $display("%0d input transactions, %0d multiplies, %0d product elements checked",
             sent, multiplies, board.checked);
    $display("covered saturation, empty products, oversized registers and ignored kinds");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ccs_pkg.sv
hw/rtl/ccs_ram.sv
hw/rtl/ccs_mac.sv
hw/rtl/sparse_ccs_matrix_multiply.sv
test/testbench.sv
